/* hdl/fat_tree_route_compute_unit_assert.svh */
// Assertion macros for the fat-tree route computation unit.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef FAT_TREE_ROUTE_COMPUTE_UNIT_ASSERT_SVH
`define FAT_TREE_ROUTE_COMPUTE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ftr_pkg.sv */
// Shared types and constants for the fat-tree route computation unit.
// No dependencies; used by the route core, the top level and the checker.
package ftr_pkg;

  localparam int NUM_PORTS     = 8;
  localparam int NUM_DOWN      = 4;
  localparam int PORT_W        = 4;
  localparam int HEAD_PORT_W   = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CREDIT_W_DEF  = 4;
  localparam int ADDR_W_DEF    = 4;

  localparam logic [PORT_W-1:0] PORT_QDN = 4'd8;
  localparam logic [PORT_W-1:0] PORT_QUP = 4'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUTER_LEVEL = 2'd0,
    CFG_RANGE_LOW    = 2'd1,
    CFG_RANGE_HIGH   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic up_full;
    logic down_full;
    logic up_empty;
    logic down_empty;
  } qstat_t;

  typedef struct packed {
    logic                   valid;
    logic [HEAD_PORT_W-1:0] port;
  } head_req_t;

endpackage

/* hdl/ftr_route_core.sv */
// Combinational route computation for all eight inputs and both queue heads.
// Depends on ftr_pkg for port codes, queue status and head request types.
module ftr_route_core #(
  parameter int CREDIT_WIDTH = ftr_pkg::CREDIT_W_DEF,
  parameter int ADDR_WIDTH   = ftr_pkg::ADDR_W_DEF
) (
  input  logic                                          router_level,
  input  logic [ADDR_WIDTH-1:0]                         range_low,
  input  logic [ADDR_WIDTH-1:0]                         range_high,
  input  logic [ftr_pkg::NUM_PORTS-1:0]                 request_mask,
  input  logic [ftr_pkg::NUM_PORTS*ADDR_WIDTH-1:0]      dest_packed,
  input  logic [ftr_pkg::NUM_PORTS*CREDIT_WIDTH-1:0]    credits_packed,
  input  ftr_pkg::qstat_t                               qstat,
  input  logic [ADDR_WIDTH-1:0]                         up_head_dest,
  input  logic [ADDR_WIDTH-1:0]                         down_head_dest,
  input  logic [ADDR_WIDTH-1:0]                         held_up,
  input  logic [ADDR_WIDTH-1:0]                         held_down,
  output logic [ftr_pkg::NUM_PORTS-1:0]                 grant_mask,
  output logic [ftr_pkg::NUM_PORTS*ftr_pkg::PORT_W-1:0] port_packed,
  output logic [ADDR_WIDTH-1:0]                         up_target,
  output logic [ADDR_WIDTH-1:0]                         down_target,
  output ftr_pkg::head_req_t                            up_head_req,
  output ftr_pkg::head_req_t                            down_head_req
);
  import ftr_pkg::*;

  // Maps a destination to its down port; valid is low when the port is outside 0..7.
  function automatic head_req_t map_down(input logic level, input logic [ADDR_WIDTH-1:0] low,
                                         input logic [ADDR_WIDTH-1:0] dest);
    logic signed [ADDR_WIDTH+1:0] t;
    logic [ADDR_WIDTH-1:0]        q;
    head_req_t                    m;
    t = $signed({2'b00, low}) - $signed({2'b00, dest}) + $signed((ADDR_WIDTH+2)'(3));
    q = dest >> 2;
    if (level) begin
      m.valid = (q <= ADDR_WIDTH'(3));
      m.port  = 3'd3 - {1'b0, q[1:0]};
    end else begin
      m.valid = (t[ADDR_WIDTH+1:3] == '0);
      m.port  = t[2:0];
    end
    return m;
  endfunction

  logic [CREDIT_WIDTH-1:0] cred [NUM_PORTS];
  logic [NUM_PORTS-1:0]    cred_nz;
  logic [ADDR_WIDTH-1:0]   lane_dest [NUM_PORTS];
  head_req_t               lane_map [NUM_PORTS];
  logic [NUM_PORTS-1:0]    lane_local;
  logic [NUM_PORTS-1:0]    lane_direct;

  for (genvar g = 0; g < NUM_PORTS; g++) begin : g_lane
    assign cred[g]        = credits_packed[g*CREDIT_WIDTH +: CREDIT_WIDTH];
    assign cred_nz[g]     = |cred[g];
    assign lane_dest[g]   = dest_packed[g*ADDR_WIDTH +: ADDR_WIDTH];
    assign lane_map[g]    = map_down(router_level, range_low, lane_dest[g]);
    assign lane_local[g]  = (lane_dest[g] >= range_low) && (lane_dest[g] <= range_high);
    assign lane_direct[g] = lane_map[g].valid && cred_nz[lane_map[g].port];
  end

  // Up port with the most credits; the lower port wins ties.
  logic                    pick_a;
  logic                    pick_b;
  logic                    pick_hi;
  logic [CREDIT_WIDTH-1:0] cred_a;
  logic [CREDIT_WIDTH-1:0] cred_b;
  logic [CREDIT_WIDTH-1:0] best_cred;
  logic [1:0]              best_idx;
  logic [PORT_W-1:0]       best_port;

  always_comb begin
    pick_a    = cred[5] > cred[4];
    pick_b    = cred[7] > cred[6];
    cred_a    = pick_a ? cred[5] : cred[4];
    cred_b    = pick_b ? cred[7] : cred[6];
    pick_hi   = cred_b > cred_a;
    best_cred = pick_hi ? cred_b : cred_a;
    best_idx  = pick_hi ? {1'b1, pick_b} : {1'b0, pick_a};
    best_port = {2'b01, best_idx};
  end

  always_comb begin
    grant_mask  = '0;
    port_packed = '0;
    up_target   = held_up;
    down_target = held_down;
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (request_mask[i]) begin
        if (lane_local[i]) begin
          if (lane_direct[i]) begin
            grant_mask[i]                 = 1'b1;
            port_packed[i*PORT_W +: PORT_W] = {1'b0, lane_map[i].port};
          end else if (i < NUM_DOWN) begin
            if (!qstat.down_full) begin
              grant_mask[i]                 = 1'b1;
              port_packed[i*PORT_W +: PORT_W] = PORT_QDN;
              down_target                   = lane_dest[i];
            end
          end else begin
            if (!qstat.up_full) begin
              grant_mask[i]                 = 1'b1;
              port_packed[i*PORT_W +: PORT_W] = PORT_QUP;
              up_target                     = lane_dest[i];
            end
          end
        end else if (best_cred != '0) begin
          grant_mask[i]                 = 1'b1;
          port_packed[i*PORT_W +: PORT_W] = best_port;
        end
      end
    end
  end

  head_req_t up_map;
  head_req_t down_map;

  always_comb begin
    up_map             = map_down(router_level, range_low, up_head_dest);
    down_map           = map_down(router_level, range_low, down_head_dest);
    up_head_req.valid  = !qstat.up_empty && up_map.valid && cred_nz[up_map.port];
    up_head_req.port   = up_head_req.valid ? up_map.port : '0;
    down_head_req.valid = !qstat.down_empty && down_map.valid && cred_nz[down_map.port];
    down_head_req.port = down_head_req.valid ? down_map.port : '0;
  end

endmodule

/* hdl/fat_tree_route_compute_unit.sv */
// Top level of the fat-tree route computation unit: configuration registers,
// input register, result register and held queue targets; uses ftr_pkg and ftr_route_core.
//
//   channel | handshake            | carries
//   --------+----------------------+---------------------------------------------
//   cfg     | cfg_we               | router_level, range_low, range_high writes
//   in      | in_valid / in_ready  | request mask, destinations, credits, queues
//   out     | out_valid / out_ready| grants, ports, queue targets, head requests
//
// One transaction per cycle while out_ready holds; each input passes the input register, then the result register.
// The path from the input register to the result register is the route core alone.
// The result register stalls on out_ready; while the result waits the input register
// still takes one transaction, and then in_ready stays low until out_ready returns.
// Reset is synchronous; it clears the valids and held targets and restores the
// configuration defaults.
module fat_tree_route_compute_unit #(
  parameter int CREDIT_WIDTH = ftr_pkg::CREDIT_W_DEF,
  parameter int ADDR_WIDTH   = ftr_pkg::ADDR_W_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cfg_we,
  input  logic [ftr_pkg::CFG_IDX_W-1:0]                 cfg_index,
  input  logic [ADDR_WIDTH-1:0]                         cfg_wdata,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [ftr_pkg::NUM_PORTS-1:0]                 in_request_mask,
  input  logic [ftr_pkg::NUM_PORTS*ADDR_WIDTH-1:0]      in_dest_packed,
  input  logic [ftr_pkg::NUM_PORTS*CREDIT_WIDTH-1:0]    in_credits_packed,
  input  logic                                          in_up_queue_full,
  input  logic                                          in_down_queue_full,
  input  logic                                          in_up_queue_empty,
  input  logic                                          in_down_queue_empty,
  input  logic [ADDR_WIDTH-1:0]                         in_up_head_dest,
  input  logic [ADDR_WIDTH-1:0]                         in_down_head_dest,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [ftr_pkg::NUM_PORTS-1:0]                 out_grant_valid_mask,
  output logic [ftr_pkg::NUM_PORTS*ftr_pkg::PORT_W-1:0] out_port_packed,
  output logic [ADDR_WIDTH-1:0]                         out_up_queue_target,
  output logic [ADDR_WIDTH-1:0]                         out_down_queue_target,
  output logic                                          out_up_head_req_valid,
  output logic [ftr_pkg::HEAD_PORT_W-1:0]               out_up_head_req_port,
  output logic                                          out_down_head_req_valid,
  output logic [ftr_pkg::HEAD_PORT_W-1:0]               out_down_head_req_port
);
  import ftr_pkg::*;

  logic                  level_r;
  logic [ADDR_WIDTH-1:0] range_low_r;
  logic [ADDR_WIDTH-1:0] range_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r      <= 1'b0;
      range_low_r  <= ADDR_WIDTH'(0);
      range_high_r <= ADDR_WIDTH'(3);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROUTER_LEVEL: level_r      <= cfg_wdata[0];
        CFG_RANGE_LOW:    range_low_r  <= cfg_wdata;
        CFG_RANGE_HIGH:   range_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic                               s1_v_r;
  logic                               s1_v_nxt;
  logic [NUM_PORTS-1:0]               s1_req_r;
  logic [NUM_PORTS*ADDR_WIDTH-1:0]    s1_dest_r;
  logic [NUM_PORTS*CREDIT_WIDTH-1:0]  s1_cred_r;
  qstat_t                             s1_qstat_r;
  logic [ADDR_WIDTH-1:0]              s1_up_head_r;
  logic [ADDR_WIDTH-1:0]              s1_down_head_r;
  logic                               out_v_r;
  logic                               out_v_nxt;
  logic                               in_fire;
  logic                               s1_adv;

  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_v_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    out_v_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r       <= in_request_mask;
      s1_dest_r      <= in_dest_packed;
      s1_cred_r      <= in_credits_packed;
      s1_qstat_r     <= '{up_full: in_up_queue_full, down_full: in_down_queue_full,
                          up_empty: in_up_queue_empty, down_empty: in_down_queue_empty};
      s1_up_head_r   <= in_up_head_dest;
      s1_down_head_r <= in_down_head_dest;
    end
  end

  logic [NUM_PORTS-1:0]        grant_nxt;
  logic [NUM_PORTS*PORT_W-1:0] ports_nxt;
  logic [ADDR_WIDTH-1:0]       held_up_r;
  logic [ADDR_WIDTH-1:0]       held_down_r;
  logic [ADDR_WIDTH-1:0]       held_up_nxt;
  logic [ADDR_WIDTH-1:0]       held_down_nxt;
  head_req_t                   up_req_nxt;
  head_req_t                   down_req_nxt;

  ftr_route_core #(
    .CREDIT_WIDTH(CREDIT_WIDTH),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_core (
    .router_level  (level_r),
    .range_low     (range_low_r),
    .range_high    (range_high_r),
    .request_mask  (s1_req_r),
    .dest_packed   (s1_dest_r),
    .credits_packed(s1_cred_r),
    .qstat         (s1_qstat_r),
    .up_head_dest  (s1_up_head_r),
    .down_head_dest(s1_down_head_r),
    .held_up       (held_up_r),
    .held_down     (held_down_r),
    .grant_mask    (grant_nxt),
    .port_packed   (ports_nxt),
    .up_target     (held_up_nxt),
    .down_target   (held_down_nxt),
    .up_head_req   (up_req_nxt),
    .down_head_req (down_req_nxt)
  );

  // The held targets double as the result register for the queue targets.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_up_r   <= '0;
      held_down_r <= '0;
    end else if (s1_adv) begin
      held_up_r   <= held_up_nxt;
      held_down_r <= held_down_nxt;
    end
  end

  logic [NUM_PORTS-1:0]        out_grant_r;
  logic [NUM_PORTS*PORT_W-1:0] out_ports_r;
  head_req_t                   out_up_req_r;
  head_req_t                   out_down_req_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_grant_r    <= grant_nxt;
      out_ports_r    <= ports_nxt;
      out_up_req_r   <= up_req_nxt;
      out_down_req_r <= down_req_nxt;
    end
  end

  assign out_valid               = out_v_r;
  assign out_grant_valid_mask    = out_grant_r;
  assign out_port_packed         = out_ports_r;
  assign out_up_queue_target     = held_up_r;
  assign out_down_queue_target   = held_down_r;
  assign out_up_head_req_valid   = out_up_req_r.valid;
  assign out_up_head_req_port    = out_up_req_r.port;
  assign out_down_head_req_valid = out_down_req_r.valid;
  assign out_down_head_req_port  = out_down_req_r.port;

endmodule

/* hdl/ftr_checker.sv */
// Port-level checks on the result channel of the fat-tree route computation unit.
// Depends on ftr_pkg and the macros header; bound to the top level below.
`include "fat_tree_route_compute_unit_assert.svh"

module ftr_checker (
  input logic                                          clk,
  input logic                                          rst_n,
  input logic                                          out_valid,
  input logic                                          out_ready,
  input logic [ftr_pkg::NUM_PORTS-1:0]                 out_grant_valid_mask,
  input logic [ftr_pkg::NUM_PORTS*ftr_pkg::PORT_W-1:0] out_port_packed,
  input logic                                          out_up_head_req_valid,
  input logic [ftr_pkg::HEAD_PORT_W-1:0]               out_up_head_req_port,
  input logic                                          out_down_head_req_valid,
  input logic [ftr_pkg::HEAD_PORT_W-1:0]               out_down_head_req_port
);
  import ftr_pkg::*;

  // A stalled input must show port 0, each queue code belongs to its own half, and no code lies above PORT_QUP.
  logic bad_port;

  always_comb begin
    bad_port = 1'b0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (!out_grant_valid_mask[i] && (out_port_packed[i*PORT_W +: PORT_W] != '0)) begin
        bad_port = 1'b1;
      end
      if (i < NUM_DOWN && out_port_packed[i*PORT_W +: PORT_W] == PORT_QUP) begin
        bad_port = 1'b1;
      end
      if (i >= NUM_DOWN && out_port_packed[i*PORT_W +: PORT_W] == PORT_QDN) begin
        bad_port = 1'b1;
      end
      if (out_port_packed[i*PORT_W +: PORT_W] > PORT_QUP) begin
        bad_port = 1'b1;
      end
    end
  end

  `FTR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_port_packed), "result changed while stalled")
  `FTR_ASSERT_NOW(a_port_codes, out_valid, !bad_port, "illegal port code in result")
  `FTR_ASSERT_NOW(a_head_idle, out_valid, (out_up_head_req_valid || out_up_head_req_port == '0) && (out_down_head_req_valid || out_down_head_req_port == '0), "head port set without request")
  `FTR_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_valid, "result valid right after reset")

endmodule

bind fat_tree_route_compute_unit ftr_checker u_ftr_checker (.*);
